### hdl/cte_pkg.sv
// Shared widths, constants and tables of the covariance-to-ellipse pipeline.
package cte_pkg;

   // Transaction layout
   localparam int FLD_W  = 32;
   localparam int REQ_W  = 3 * FLD_W;
   localparam int ANG_W  = 20;
   localparam int SIG_W  = 24;
   localparam int RSP_W  = 72;
   localparam int TOL_W  = 16;

   // Register map
   localparam int        CSR_AW    = 3;
   localparam logic      REG_TOL   = 1'b0;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

   // Pipeline shape
   localparam int CORDIC_STEPS = 18;
   localparam int SQ1_STEPS    = 32;
   localparam int SQ2_STEPS    = 25;
   localparam int LAT          = 3 + SQ1_STEPS + 1 + SQ2_STEPS + 1;
   localparam int ANG_END      = CORDIC_STEPS + 4;
   localparam int ANG_DLY      = LAT - 1 - ANG_END;
   localparam int SUM_DLY      = 2 + SQ1_STEPS;

   // Angle constants in Q2.30
   localparam logic signed [35:0] PI_Q30   = 36'sd3373259426;
   localparam logic signed [35:0] PI2_Q30  = 36'sd1686629713;
   localparam logic signed [35:0] PI4_Q30  = 36'sd843314857;
   localparam logic signed [35:0] PI34_Q30 = 36'sd2529944570;
   localparam logic signed [35:0] RND_Q16  = 36'sd8192;

   typedef struct packed {
      logic eq;
      logic pos;
      logic zero;
      logic gt;
      logic neg;
      logic nz;
   } flags_type;

   // atan(2^-i) in Q2.30, truncated
   function automatic logic [31:0] atan_q30(input int i);
      logic [31:0] a;
      case (i)
         0:  a = 32'h3243F6A8;
         1:  a = 32'h1DAC6705;
         2:  a = 32'h0FADBAFC;
         3:  a = 32'h07F56EA6;
         4:  a = 32'h03FEAB76;
         5:  a = 32'h01FFD55B;
         6:  a = 32'h00FFFAAA;
         7:  a = 32'h007FFF55;
         8:  a = 32'h003FFFEA;
         9:  a = 32'h001FFFFD;
         10: a = 32'h000FFFFF;
         11: a = 32'h0007FFFF;
         12: a = 32'h0003FFFF;
         13: a = 32'h0001FFFF;
         14: a = 32'h0000FFFF;
         15: a = 32'h00007FFF;
         16: a = 32'h00003FFF;
         17: a = 32'h00001FFF;
         18: a = 32'h00000FFF;
         19: a = 32'h000007FF;
         20: a = 32'h000003FF;
         21: a = 32'h000001FF;
         22: a = 32'h000000FF;
         23: a = 32'h0000007F;
         24: a = 32'h0000003F;
         25: a = 32'h0000001F;
         26: a = 32'h0000000F;
         27: a = 32'h00000007;
         28: a = 32'h00000003;
         29: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

### hdl/covariance_to_ellipse_top.sv
// Covariance-to-error-ellipse pipeline: CORDIC angle and two square-root chains.
//
//  channel | dir | contents
//  req_    | in  | tdata: covar_xx[31:0], covar_yy[63:32], covar_xy[95:64]
//  rsp_    | out | tdata: angle_rad, major_sigma, minor_sigma; tuser: invalid
//  csr_    | in  | tolerance register at byte address 0
//
// One transaction per cycle while the output is not stalled; each result passes
// through the bit-per-stage square roots (32 then 25 stages) before it leaves.
// Reset clears the valid bits and loads tolerance with 7.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module covariance_to_ellipse_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [cte_pkg::REQ_W-1:0]    req_tdata,   // covar_xx, covar_yy, covar_xy
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [cte_pkg::RSP_W-1:0]    rsp_tdata,   // angle_rad, major_sigma, minor_sigma
   output logic [0:0]                   rsp_tuser,   // invalid
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [cte_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import cte_pkg::*;

   logic                 adv;
   logic [LAT-1:0]       vld_ff;
   logic [TOL_W-1:0]     tol_ff;
   logic                 csr_wr;

   // Stage 1
   logic signed [32:0]   d_ff, num_ff;
   logic [31:0]          ad_ff, ac_ff;
   flags_type            flg_ff;
   logic signed [32:0]   sum_dl_ff [0:SUM_DLY];

   // Angle path
   logic [58:0]          nu_ff, nd_ff;
   flags_type            nf_ff;
   logic signed [63:0]   cx_ff [0:CORDIC_STEPS];
   logic signed [63:0]   cy_ff [0:CORDIC_STEPS];
   logic signed [33:0]   cz_ff [0:CORDIC_STEPS];
   flags_type            cf_ff [0:CORDIC_STEPS];
   logic [ANG_W-1:0]     q_dl_ff [0:ANG_DLY];

   // Square-root path
   logic [63:0]          p1_ff, p2_ff;
   logic [63:0]          s1v_ff [0:SQ1_STEPS];
   logic [63:0]          s1r_ff [0:SQ1_STEPS];
   logic [49:0]          mjv_ff [0:SQ2_STEPS];
   logic [49:0]          mjr_ff [0:SQ2_STEPS];
   logic [49:0]          mnv_ff [0:SQ2_STEPS];
   logic [49:0]          mnr_ff [0:SQ2_STEPS];
   logic                 bad_ff [0:SQ2_STEPS];

   // Output register
   logic [ANG_W-1:0]     ang_ff;
   logic [SIG_W-1:0]     maj_ff, min_ff;
   logic                 inv_ff;

   // Stage 1 combinational
   logic signed [31:0]   sxx, syy, sxy;
   logic signed [32:0]   d_in, sxy33, sum_in, num_in;
   logic [32:0]          ad_in, ac_in, tol33;
   flags_type            flg_in;

   // Normalize combinational
   logic [32:0]          un, ud;
   logic [58:0]          n1u, n1d, n2u, n2d;
   flags_type            nf_in;

   // Angle finish combinational
   logic signed [35:0]   zz, thc, th, q_c;
   flags_type            ff;

   // Radicand combinational
   logic [33:0]          f2;
   logic signed [34:0]   rmaj, rmin;
   logic [49:0]          radmaj, radmin;

   // Whole pipeline advances unless the output holds an untaken result
   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TOL) ? {16'b0, tol_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr && csr_paddr[2] == REG_TOL) begin
         tol_ff <= csr_pwdata[TOL_W-1:0];
      end
   end

   // Difference, magnitudes and comparison flags
   always_comb begin
      sxx    = req_tdata[31:0];
      syy    = req_tdata[63:32];
      sxy    = req_tdata[95:64];
      d_in   = {sxx[31], sxx} - {syy[31], syy};
      sxy33  = {sxy[31], sxy};
      sum_in = {sxx[31], sxx} + {syy[31], syy};
      num_in = {sxy, 1'b0};
      ad_in  = d_in[32] ? 33'(-d_in) : 33'(d_in);
      ac_in  = sxy33[32] ? 33'(-sxy33) : 33'(sxy33);
      tol33  = {17'b0, tol_ff};
      flg_in      = '0;
      flg_in.eq   = ad_in < tol33;
      flg_in.pos  = sxy33 > $signed(tol33);
      flg_in.zero = ac_in < tol33;
      flg_in.gt   = sxx > syy;
   end

   // Normalize: coarse shifts by 32, 16, 8
   always_comb begin
      un  = num_ff[32] ? 33'(-num_ff) : 33'(num_ff);
      ud  = d_ff[32] ? 33'(-d_ff) : 33'(d_ff);
      n1u = {26'b0, un};
      n1d = {26'b0, ud};
      if ((n1u[58:27] | n1d[58:27]) == '0) begin
         n1u = n1u << 32;
         n1d = n1d << 32;
      end
      if ((n1u[58:43] | n1d[58:43]) == '0) begin
         n1u = n1u << 16;
         n1d = n1d << 16;
      end
      if ((n1u[58:51] | n1d[58:51]) == '0) begin
         n1u = n1u << 8;
         n1d = n1d << 8;
      end
      nf_in     = flg_ff;
      nf_in.neg = num_ff[32] ^ d_ff[32];
      nf_in.nz  = num_ff != '0;
   end

   // Normalize: fine shifts by 4, 2, 1
   always_comb begin
      n2u = nu_ff;
      n2d = nd_ff;
      if ((n2u[58:55] | n2d[58:55]) == '0) begin
         n2u = n2u << 4;
         n2d = n2d << 4;
      end
      if ((n2u[58:57] | n2d[58:57]) == '0) begin
         n2u = n2u << 2;
         n2d = n2d << 2;
      end
      if ((n2u[58] | n2d[58]) == 1'b0) begin
         n2u = n2u << 1;
         n2d = n2d << 1;
      end
   end

   // Halve, apply sign and quadrant offset, round to Q3.16
   always_comb begin
      ff  = cf_ff[CORDIC_STEPS];
      zz  = 36'(cz_ff[CORDIC_STEPS]);
      if (!ff.nz) begin
         zz = '0;
      end else if (ff.neg) begin
         zz = -zz;
      end
      thc = zz >>> 1;
      if (ff.eq && ff.zero) begin
         th = '0;
      end else if (ff.eq && ff.pos) begin
         th = PI4_Q30;
      end else if (ff.eq) begin
         th = PI34_Q30;
      end else if (ff.gt && !ff.pos) begin
         th = thc + PI_Q30;
      end else if (!ff.gt) begin
         th = thc + PI2_Q30;
      end else begin
         th = thc;
      end
      q_c = (th + RND_Q16) >>> 14;
   end

   // Axis radicands from the root of the discriminant
   always_comb begin
      f2     = {1'b0, s1r_ff[SQ1_STEPS][31:0], 1'b0};
      rmaj   = 35'(sum_dl_ff[SUM_DLY]) + $signed({1'b0, f2});
      rmin   = 35'(sum_dl_ff[SUM_DLY]) - $signed({1'b0, f2});
      radmaj = rmaj[34] ? 50'd0 : {1'b0, rmaj[33:0], 15'b0};
      radmin = rmin[34] ? 50'd0 : {1'b0, rmin[33:0], 15'b0};
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         // entry stage
         d_ff         <= d_in;
         num_ff       <= num_in;
         ad_ff        <= ad_in[31:0];
         ac_ff        <= ac_in[31:0];
         flg_ff       <= flg_in;
         sum_dl_ff[0] <= sum_in;
         for (int k = 1; k <= SUM_DLY; k++) begin
            sum_dl_ff[k] <= sum_dl_ff[k-1];
         end

         // normalize
         nu_ff    <= n1u;
         nd_ff    <= n1d;
         nf_ff    <= nf_in;
         cx_ff[0] <= {5'b0, n2d};
         cy_ff[0] <= {5'b0, n2u};
         cz_ff[0] <= '0;
         cf_ff[0] <= nf_ff;

         // CORDIC vectoring, one rotation per stage
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cf_ff[i+1] <= cf_ff[i];
            if (!cy_ff[i][63]) begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + $signed({2'b0, atan_q30(i)});
            end else begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - $signed({2'b0, atan_q30(i)});
            end
         end

         // angle result, delayed to meet the axis lengths
         q_dl_ff[0] <= q_c[ANG_W-1:0];
         for (int k = 1; k <= ANG_DLY; k++) begin
            q_dl_ff[k] <= q_dl_ff[k-1];
         end

         // discriminant squares and sum
         p1_ff     <= ad_ff * ad_ff;
         p2_ff     <= ac_ff * ac_ff;
         s1v_ff[0] <= (p1_ff >> 2) + p2_ff;
         s1r_ff[0] <= '0;

         // discriminant root, one bit per stage
         for (int j = 0; j < SQ1_STEPS; j++) begin
            if (s1v_ff[j] >= s1r_ff[j] + (64'd1 << (62 - 2*j))) begin
               s1v_ff[j+1] <= s1v_ff[j] - (s1r_ff[j] + (64'd1 << (62 - 2*j)));
               s1r_ff[j+1] <= (s1r_ff[j] >> 1) + (64'd1 << (62 - 2*j));
            end else begin
               s1v_ff[j+1] <= s1v_ff[j];
               s1r_ff[j+1] <= s1r_ff[j] >> 1;
            end
         end

         // axis radicands, clamped
         mjv_ff[0] <= radmaj;
         mnv_ff[0] <= radmin;
         mjr_ff[0] <= '0;
         mnr_ff[0] <= '0;
         bad_ff[0] <= rmaj[34] | rmin[34];

         // axis roots, one bit per stage
         for (int j = 0; j < SQ2_STEPS; j++) begin
            bad_ff[j+1] <= bad_ff[j];
            if (mjv_ff[j] >= mjr_ff[j] + (50'd1 << (48 - 2*j))) begin
               mjv_ff[j+1] <= mjv_ff[j] - (mjr_ff[j] + (50'd1 << (48 - 2*j)));
               mjr_ff[j+1] <= (mjr_ff[j] >> 1) + (50'd1 << (48 - 2*j));
            end else begin
               mjv_ff[j+1] <= mjv_ff[j];
               mjr_ff[j+1] <= mjr_ff[j] >> 1;
            end
            if (mnv_ff[j] >= mnr_ff[j] + (50'd1 << (48 - 2*j))) begin
               mnv_ff[j+1] <= mnv_ff[j] - (mnr_ff[j] + (50'd1 << (48 - 2*j)));
               mnr_ff[j+1] <= (mnr_ff[j] >> 1) + (50'd1 << (48 - 2*j));
            end else begin
               mnv_ff[j+1] <= mnv_ff[j];
               mnr_ff[j+1] <= mnr_ff[j] >> 1;
            end
         end

         // output register with saturation
         ang_ff <= q_dl_ff[ANG_DLY];
         maj_ff <= (mjr_ff[SQ2_STEPS][49:SIG_W] != '0) ? '1 : mjr_ff[SQ2_STEPS][SIG_W-1:0];
         min_ff <= (mnr_ff[SQ2_STEPS][49:SIG_W] != '0) ? '1 : mnr_ff[SQ2_STEPS][SIG_W-1:0];
         inv_ff <= bad_ff[SQ2_STEPS];
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {4'b0, min_ff, maj_ff, ang_ff};
   assign rsp_tuser  = inv_ff;

endmodule

### hdl/cte_check.sv
// Port-level checker for the covariance-to-ellipse pipeline, bound to the top level.
module cte_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [cte_pkg::RSP_W-1:0]    rsp_tdata,
   input logic [0:0]                   rsp_tuser,
   input logic                         csr_psel,
   input logic                         csr_penable,
   input logic                         csr_pwrite,
   input logic [cte_pkg::CSR_AW-1:0]   csr_paddr,
   input logic [31:0]                  csr_pwdata,
   input logic [31:0]                  csr_prdata,
   input logic                         csr_pready
);
   import cte_pkg::*;

   // Hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Drain all results on reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Clamped radicand leaves the minor axis at zero
   a_inv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[67:44] == '0)
      else $error("invalid with nonzero minor axis");

   // Major axis never shorter than minor axis
   a_ord: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[43:20] >= rsp_tdata[67:44])
      else $error("major axis below minor axis");

   // Tolerance reads back what was written
   a_csr: assert property (@(posedge clock) disable iff (reset)
      $past(csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[2] == REG_TOL)
      && !$past(reset) && csr_paddr[2] == REG_TOL
      |-> csr_prdata[TOL_W-1:0] == $past(csr_pwdata[TOL_W-1:0]))
      else $error("tolerance readback mismatch");

endmodule

bind covariance_to_ellipse_top cte_check u_cte_check (.*);
